// ----- rtl/differential_drive_odometry_core_macros.svh -----
// assertion helpers for the odometry core
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DDO_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DDO_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/ddo_pkg.sv -----
package ddo_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int TRIG_ITERATIONS = 24;
   localparam int HEAD_SHIFT      = 2 * FRAC_BITS - 28;
   localparam int MOD_STEPS       = 30;

   localparam logic signed [30:0] PI_Q28      = 31'sd843314857;
   localparam logic [30:0]        TWO_PI_Q28  = 31'd1686629713;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [1:0] OP_SET_WHEELS = 2'd0;
   localparam logic [1:0] OP_SET_DRIVE  = 2'd1;
   localparam logic [1:0] OP_ADVANCE    = 2'd2;

   localparam logic [2:0] CSR_MAX_SPEED  = 3'd0;
   localparam logic [2:0] CSR_WHEEL_DIST = 3'd1;
   localparam logic [2:0] CSR_OFFSET_X   = 3'd2;
   localparam logic [2:0] CSR_OFFSET_Y   = 3'd3;
   localparam logic [2:0] CSR_TIME_STEP  = 3'd4;

   localparam logic [30:0] MAX_SPEED_RST  = 31'd6553600;
   localparam logic [30:0] WHEEL_DIST_RST = 31'd1310720;
   localparam logic [31:0] TIME_STEP_RST  = 32'd655;

   typedef struct packed {
      logic               set_wheels;
      logic               mix;
      logic               advance;
      logic signed [31:0] first;
      logic signed [31:0] second;
   } item_type;

   typedef struct packed {
      logic               done;
      logic signed [32:0] cos_val;
      logic signed [32:0] sin_val;
   } trig_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } quot_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      case (idx)
         5'd0:  return 30'd843314856;
         5'd1:  return 30'd497837829;
         5'd2:  return 30'd263043836;
         5'd3:  return 30'd133525158;
         5'd4:  return 30'd67021686;
         5'd5:  return 30'd33543515;
         5'd6:  return 30'd16775850;
         5'd7:  return 30'd8388437;
         5'd8:  return 30'd4194282;
         5'd9:  return 30'd2097149;
         5'd10: return 30'd1048575;
         5'd11: return 30'd524287;
         5'd12: return 30'd262143;
         5'd13: return 30'd131071;
         5'd14: return 30'd65535;
         5'd15: return 30'd32767;
         5'd16: return 30'd16383;
         5'd17: return 30'd8191;
         5'd18: return 30'd4095;
         5'd19: return 30'd2047;
         5'd20: return 30'd1023;
         5'd21: return 30'd511;
         5'd22: return 30'd255;
         5'd23: return 30'd127;
         5'd24: return 30'd63;
         5'd25: return 30'd31;
         5'd26: return 30'd15;
         5'd27: return 30'd7;
         5'd28: return 30'd3;
         5'd29: return 30'd1;
         default: return 30'd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [31:0] clamp_speed(input logic signed [65:0] s,
                                                      input logic [30:0] m);
      logic signed [65:0] mx;
      logic signed [65:0] mn;
      mx = $signed({35'd0, m});
      mn = -mx;
      if (s > mx) begin
         return mx[31:0];
      end else if (s < mn) begin
         return mn[31:0];
      end else begin
         return s[31:0];
      end
   endfunction

endpackage

// ----- rtl/ddo_front.sv -----
module ddo_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // first_command, second_command
   input  logic [1:0]         req_tuser,   // operation
   output logic               item_valid,
   input  logic               item_ready,
   output ddo_pkg::item_type  item
);

   ddo_pkg::item_type entry_ff [2];
   ddo_pkg::item_type cls;
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   always_comb begin
      cls            = '0;
      cls.first      = req_tdata[31:0];
      cls.second     = req_tdata[63:32];
      case (req_tuser)
         ddo_pkg::OP_SET_WHEELS: cls.set_wheels = 1'b1;
         ddo_pkg::OP_SET_DRIVE:  cls.mix        = 1'b1;
         ddo_pkg::OP_ADVANCE:    cls.advance    = 1'b1;
         default:                cls.advance    = 1'b0;  // unused code only reports
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/ddo_cordic.sv -----
module ddo_cordic #(
   parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITERATIONS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [30:0] heading,
   output ddo_pkg::trig_type  result
);

   localparam logic [4:0] LAST = 5'(TRIG_ITERATIONS - 1);

   logic signed [32:0] x_ff;
   logic signed [32:0] y_ff;
   logic signed [34:0] z_ff;
   logic [4:0]         idx_ff;
   logic               neg_ff;
   logic               busy_ff;
   logic               done_ff;

   logic signed [34:0] z0;
   logic signed [34:0] z_fold;
   logic               neg_in;
   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [34:0] at;

   always_comb begin
      z0     = $signed({{2{heading[30]}}, heading, 2'b00});
      z_fold = z0;
      neg_in = 1'b0;
      // fold into the half plane the iterations converge on
      if (z0 > ddo_pkg::HALF_PI_Q30) begin
         z_fold = z0 - ddo_pkg::PI_Q30;
         neg_in = 1'b1;
      end else if (z0 < -ddo_pkg::HALF_PI_Q30) begin
         z_fold = z0 + ddo_pkg::PI_Q30;
         neg_in = 1'b1;
      end
      dx = y_ff >>> idx_ff;
      dy = x_ff >>> idx_ff;
      at = $signed({5'd0, ddo_pkg::atan_q30(idx_ff)});
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= ddo_pkg::CORDIC_GAIN;
         y_ff   <= '0;
         z_ff   <= z_fold;
         neg_ff <= neg_in;
         idx_ff <= 5'd0;
      end else if (busy_ff) begin
         if (!z_ff[34]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
         idx_ff <= idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && idx_ff == LAST) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   assign result.done    = done_ff;
   assign result.cos_val = neg_ff ? -x_ff : x_ff;
   assign result.sin_val = neg_ff ? -y_ff : y_ff;

endmodule

// ----- rtl/ddo_divider.sv -----
module ddo_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] diff,
   input  logic [30:0]        divisor,
   output ddo_pkg::quot_type  result
);

   localparam int         NUM_W = 33 + ddo_pkg::FRAC_BITS;
   localparam logic [5:0] LAST  = 6'(NUM_W - 1);

   logic [NUM_W-1:0]   quo_ff;
   logic [30:0]        rem_ff;
   logic [30:0]        den_ff;
   logic               neg_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic signed [33:0] diff_w;
   logic [32:0]        mag;
   logic [31:0]        shifted;
   logic [31:0]        trial;
   logic               ge;
   logic signed [65:0] qs;

   always_comb begin
      diff_w  = 34'(diff);
      mag     = diff_w[33] ? 33'(-diff_w) : 33'(diff_w);
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      qs      = $signed(66'(quo_ff));
      if (neg_ff) qs = -qs;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {mag, ddo_pkg::FRAC_BITS'(0)};
         rem_ff <= '0;
         den_ff <= (divisor == 31'd0) ? 31'd1 : divisor;  // zero spacing acts as one
         neg_ff <= diff[32];
         cnt_ff <= 6'd0;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial[30:0] : shifted[30:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == LAST) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   assign result.done = done_ff;
   assign result.quot = ddo_pkg::sat32(qs);

endmodule

// ----- rtl/ddo_exec.sv -----
module ddo_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic               item_valid,
   output logic               item_ready,
   input  ddo_pkg::item_type  item,
   output logic               trig_start,
   output logic signed [30:0] heading,
   input  ddo_pkg::trig_type  trig_res,
   output logic               div_start,
   output logic signed [32:0] div_diff,
   output logic [30:0]        div_divisor,
   input  ddo_pkg::quot_type  quot_res,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [191:0]       rsp_tdata
);

   localparam int F = ddo_pkg::FRAC_BITS;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MIX1 = 5'd1;
   localparam logic [4:0] S_MIX2 = 5'd2;
   localparam logic [4:0] S_MIX3 = 5'd3;
   localparam logic [4:0] S_DIV  = 5'd4;
   localparam logic [4:0] S_V1   = 5'd5;
   localparam logic [4:0] S_V2   = 5'd6;
   localparam logic [4:0] S_M    = 5'd7;
   localparam logic [4:0] S_X1   = 5'd8;
   localparam logic [4:0] S_X2   = 5'd9;
   localparam logic [4:0] S_Y1   = 5'd10;
   localparam logic [4:0] S_Y2   = 5'd11;
   localparam logic [4:0] S_PX   = 5'd12;
   localparam logic [4:0] S_PY   = 5'd13;
   localparam logic [4:0] S_HD   = 5'd14;
   localparam logic [4:0] S_MOD  = 5'd15;
   localparam logic [4:0] S_FIX  = 5'd16;
   localparam logic [4:0] S_DONE = 5'd17;

   localparam logic [4:0] MOD_LAST = 5'(ddo_pkg::MOD_STEPS - 1);

   logic [30:0]        max_speed_ff;
   logic [30:0]        wheel_dist_ff;
   logic signed [31:0] offset_x_ff;
   logic signed [31:0] offset_y_ff;
   logic [31:0]        time_step_ff;

   logic signed [31:0] left_ff;
   logic signed [31:0] right_ff;
   logic signed [31:0] pose_x_ff;
   logic signed [31:0] pose_y_ff;
   logic signed [30:0] heading_ff;
   logic [31:0]        ticks_ff;

   logic [4:0]         state_ff;
   logic signed [31:0] v_ff;
   logic signed [31:0] w_ff;
   logic signed [31:0] m_ff;
   logic signed [31:0] xd_ff;
   logic signed [31:0] yd_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] mul_ff;
   logic signed [65:0] mul_in;
   logic [59:0]        rem_ff;
   logic               neg_ff;
   logic [4:0]         kcnt_ff;
   logic               rsp_valid_ff;
   logic [191:0]       rsp_data_ff;

   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [32:0] dt_s;
   logic signed [32:0] sum_lr;
   logic signed [32:0] half_lr;
   logic signed [65:0] head_shifted;
   logic signed [61:0] head_sum;
   logic signed [61:0] head_mag;
   logic [60:0]        mod_sub;
   logic               mod_ge;
   logic [30:0]        r_val;
   logic signed [31:0] heading_in;
   logic               rsp_load;

   assign dt_s = $signed({1'b0, time_step_ff});

   // one shared multiplier, result registered before use
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MIX1: begin
            mul_a = $signed({2'b00, wheel_dist_ff});
            mul_b = 33'(w_ff);
         end
         S_MIX2, S_V1: begin
            mul_a = 33'(offset_y_ff);
            mul_b = 33'(w_ff);
         end
         S_V2: begin
            mul_a = 33'(offset_x_ff);
            mul_b = 33'(w_ff);
         end
         S_M: begin
            mul_a = trig_res.cos_val;
            mul_b = 33'(v_ff);
         end
         S_X1: begin
            mul_a = trig_res.sin_val;
            mul_b = 33'(m_ff);
         end
         S_X2: begin
            mul_a = trig_res.sin_val;
            mul_b = 33'(v_ff);
         end
         S_Y1: begin
            mul_a = trig_res.cos_val;
            mul_b = 33'(m_ff);
         end
         S_Y2: begin
            mul_a = 33'(xd_ff);
            mul_b = dt_s;
         end
         S_PX: begin
            mul_a = 33'(yd_ff);
            mul_b = dt_s;
         end
         S_PY: begin
            mul_a = 33'(w_ff);
            mul_b = dt_s;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = mul_a * mul_b;

   always_comb begin
      sum_lr       = 33'(left_ff) + 33'(right_ff);
      half_lr      = sum_lr >>> 1;
      head_shifted = mul_ff >>> ddo_pkg::HEAD_SHIFT;
      head_sum     = 62'(heading_ff) + head_shifted[61:0] + 62'(ddo_pkg::PI_Q28);
      head_mag     = head_sum[61] ? -head_sum : head_sum;
      mod_sub      = 61'(ddo_pkg::TWO_PI_Q28) << kcnt_ff;
      mod_ge       = ({1'b0, rem_ff} >= mod_sub);
      // floor modulo: a negative operand with a remainder wraps from the top
      r_val        = (neg_ff && rem_ff != 60'd0) ?
                     (ddo_pkg::TWO_PI_Q28 - rem_ff[30:0]) : rem_ff[30:0];
      heading_in   = $signed({1'b0, r_val}) - 32'(ddo_pkg::PI_Q28);
   end

   assign item_ready  = (state_ff == S_IDLE);
   assign trig_start  = (state_ff == S_IDLE) && item_valid && item.advance;
   assign div_start   = trig_start;
   assign heading     = heading_ff;
   assign div_diff    = 33'(right_ff) - 33'(left_ff);
   assign div_divisor = wheel_dist_ff;
   assign rsp_load    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, right_ff, left_ff, ticks_ff, heading_ff, pose_y_ff,
                         pose_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= ddo_pkg::MAX_SPEED_RST;
         wheel_dist_ff <= ddo_pkg::WHEEL_DIST_RST;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         time_step_ff  <= ddo_pkg::TIME_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            ddo_pkg::CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[30:0];
            ddo_pkg::CSR_WHEEL_DIST: wheel_dist_ff <= csr_wdata[30:0];
            ddo_pkg::CSR_OFFSET_X:   offset_x_ff   <= csr_wdata;
            ddo_pkg::CSR_OFFSET_Y:   offset_y_ff   <= csr_wdata;
            ddo_pkg::CSR_TIME_STEP:  time_step_ff  <= csr_wdata;
            default:                 time_step_ff  <= time_step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         ticks_ff     <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  if (item.set_wheels) begin
                     left_ff  <= ddo_pkg::clamp_speed(66'(item.first), max_speed_ff);
                     right_ff <= ddo_pkg::clamp_speed(66'(item.second), max_speed_ff);
                     state_ff <= S_DONE;
                  end else if (item.mix) begin
                     v_ff     <= item.first;
                     w_ff     <= item.second;
                     state_ff <= S_MIX1;
                  end else if (item.advance) begin
                     state_ff <= S_DIV;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_MIX1: state_ff <= S_MIX2;
            S_MIX2: begin
               acc_ff   <= mul_ff >>> 1;
               state_ff <= S_MIX3;
            end
            S_MIX3: begin
               left_ff  <= ddo_pkg::clamp_speed(66'(v_ff) - ((acc_ff - mul_ff) >>> F),
                                                max_speed_ff);
               right_ff <= ddo_pkg::clamp_speed(66'(v_ff) + ((acc_ff + mul_ff) >>> F),
                                                max_speed_ff);
               state_ff <= S_DONE;
            end
            S_DIV: begin
               if (trig_res.done && quot_res.done) begin
                  w_ff     <= quot_res.quot;
                  state_ff <= S_V1;
               end
            end
            S_V1: state_ff <= S_V2;
            S_V2: begin
               v_ff     <= ddo_pkg::sat32(66'(half_lr) - (mul_ff >>> F));
               state_ff <= S_M;
            end
            S_M: begin
               m_ff     <= ddo_pkg::sat32(mul_ff >>> F);
               state_ff <= S_X1;
            end
            S_X1: begin
               acc_ff   <= mul_ff;
               state_ff <= S_X2;
            end
            S_X2: begin
               xd_ff    <= ddo_pkg::sat32((acc_ff - mul_ff) >>> 30);
               state_ff <= S_Y1;
            end
            S_Y1: begin
               acc_ff   <= mul_ff;
               state_ff <= S_Y2;
            end
            S_Y2: begin
               yd_ff    <= ddo_pkg::sat32((acc_ff + mul_ff) >>> 30);
               state_ff <= S_PX;
            end
            S_PX: begin
               pose_x_ff <= ddo_pkg::sat32(66'(pose_x_ff) + (mul_ff >>> F));
               state_ff  <= S_PY;
            end
            S_PY: begin
               pose_y_ff <= ddo_pkg::sat32(66'(pose_y_ff) + (mul_ff >>> F));
               state_ff  <= S_HD;
            end
            S_HD: begin
               neg_ff   <= head_sum[61];
               rem_ff   <= head_mag[59:0];
               kcnt_ff  <= MOD_LAST;
               state_ff <= S_MOD;
            end
            S_MOD: begin
               // restoring reduction, one shifted multiple of two pi a cycle
               if (mod_ge) rem_ff <= rem_ff - mod_sub[59:0];
               kcnt_ff <= kcnt_ff - 5'd1;
               if (kcnt_ff == 5'd0) state_ff <= S_FIX;
            end
            S_FIX: begin
               heading_ff <= heading_in[30:0];
               ticks_ff   <= ticks_ff + 32'd1;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/differential_drive_odometry_core.sv -----
// set wheels goes straight to the result state; drive mixing runs the multiplier
// first; a step waits for the serial divider, then runs the multiplier slots and
// the heading reduction; one item in the sequencer at a time, two queued
// next item taken only after the last result loads; step bound by serial divider and wrap
// reset is synchronous: pose, heading, ticks, speeds and queue clear, registers
// return to their defaults; no clearing pass
`include "differential_drive_odometry_core_macros.svh"

module differential_drive_odometry_core #(
   parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITERATIONS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // first_command, second_command
   input  logic [1:0]   req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // position_x, position_y, heading_angle, elapsed_ticks, left_wheel_speed,
   // right_wheel_speed, zero pad
   output logic [191:0] rsp_tdata
);

   ddo_pkg::item_type  item;
   logic               item_valid;
   logic               item_ready;
   logic               trig_start;
   logic               div_start;
   logic signed [30:0] heading;
   logic signed [32:0] div_diff;
   logic [30:0]        div_divisor;
   ddo_pkg::trig_type  trig_res;
   ddo_pkg::quot_type  quot_res;

   ddo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   ddo_cordic #(
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .heading (heading),
      .result  (trig_res)
   );

   ddo_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (div_diff),
      .divisor (div_divisor),
      .result  (quot_res)
   );

   ddo_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .trig_start  (trig_start),
      .heading     (heading),
      .trig_res    (trig_res),
      .div_start   (div_start),
      .div_diff    (div_diff),
      .div_divisor (div_divisor),
      .quot_res    (quot_res),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   `DDO_ASSERT_NEXT(a_trig_busy, clock, reset, trig_start, !trig_res.done, "trig done after start")
   `DDO_ASSERT_NEXT(a_div_busy, clock, reset, div_start, !quot_res.done, "divider done after start")
   `DDO_ASSERT_IMPLIES(a_heading_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[94:64]) >= -ddo_pkg::PI_Q28) && ($signed(rsp_tdata[94:64]) < ddo_pkg::PI_Q28), "heading out of range")

endmodule

// ----- dv/differential_drive_odometry_core_checker.sv -----
module differential_drive_odometry_core_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,
   output int           errors,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PI_28     = 64'sd843314857;
   localparam longint TWO_PI_28 = 64'sd1686629713;
   localparam longint HALF_30   = 64'sd1686629713;
   localparam longint PI_30     = 64'sd3373259426;
   localparam longint GAIN_30   = 64'sd652032874;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [31:0] right;
      logic [31:0] left;
      logic [31:0] ticks;
      logic [30:0] hd;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   longint arctan_q30 [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1};

   // mirrored registers and odometry state
   longint speed_limit, track_width, ref_off_x, ref_off_y, step_len;
   longint wheel_l, wheel_r, pos_x, pos_y, yaw;
   logic [31:0] tick_cnt;
   pose_type pose_expect_q [$];

   function automatic longint limit_to(longint v, longint lim);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint clip32(longint v);
      return limit_to(v, 64'sd2147483648);
   endfunction

   function automatic longint clamp_wheel(longint s);
      if (s > speed_limit) return speed_limit;
      if (s < -speed_limit) return -speed_limit;
      return s;
   endfunction

   function automatic void sin_cos(input longint h, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = h * 4;
      x = GAIN_30;
      y = 0;
      flip = 0;
      if (z > HALF_30) begin
         z -= PI_30;
         flip = 1;
      end else if (z < -HALF_30) begin
         z += PI_30;
         flip = 1;
      end
      for (int i = 0; i < ddo_pkg::TRIG_ITERATIONS && i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_q30[i];
         end else begin
            x += dx;
            y -= dy;
            z += arctan_q30[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void integrate_step();
      longint wd, w, v, m, c, s, xd, yd, inc, r;
      wd = (track_width != 0) ? track_width : 1;
      w = clip32(((wheel_r - wheel_l) * 65536) / wd);
      v = clip32(((wheel_l + wheel_r) >>> 1) - ((ref_off_y * w) >>> ddo_pkg::FRAC_BITS));
      m = clip32((ref_off_x * w) >>> ddo_pkg::FRAC_BITS);
      sin_cos(yaw, c, s);
      xd = clip32((c * v - s * m) >>> 30);
      yd = clip32((s * v + c * m) >>> 30);
      pos_x = clip32(pos_x + ((xd * step_len) >>> ddo_pkg::FRAC_BITS));
      pos_y = clip32(pos_y + ((yd * step_len) >>> ddo_pkg::FRAC_BITS));
      inc = limit_to((w * step_len) >>> ddo_pkg::HEAD_SHIFT, 64'sd1 <<< 61);
      r = (yaw + inc + PI_28) % TWO_PI_28;
      if (r < 0) r += TWO_PI_28;
      yaw = r - PI_28;
      tick_cnt = tick_cnt + 32'd1;
   endfunction

   function automatic pose_type predict_pose(logic [1:0] op, longint a, longint b);
      pose_type p;
      longint half, side;
      if (op == ddo_pkg::OP_SET_WHEELS) begin
         wheel_l = clamp_wheel(a);
         wheel_r = clamp_wheel(b);
      end else if (op == ddo_pkg::OP_SET_DRIVE) begin
         half = (track_width * b) >>> 1;
         side = ref_off_y * b;
         wheel_l = clamp_wheel(a - ((half - side) >>> ddo_pkg::FRAC_BITS));
         wheel_r = clamp_wheel(a + ((half + side) >>> ddo_pkg::FRAC_BITS));
      end else if (op == ddo_pkg::OP_ADVANCE) begin
         integrate_step();
      end
      p.x = pos_x[31:0];
      p.y = pos_y[31:0];
      p.hd = yaw[30:0];
      p.ticks = tick_cnt;
      p.left = wheel_l[31:0];
      p.right = wheel_r[31:0];
      return p;
   endfunction

   function automatic int field_differs(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      pose_type e, g;
      int bad;
      if (reset) begin
         speed_limit = 6553600;
         track_width = 1310720;
         ref_off_x = 0;
         ref_off_y = 0;
         step_len = 655;
         wheel_l = 0;
         wheel_r = 0;
         pos_x = 0;
         pos_y = 0;
         yaw = 0;
         tick_cnt = 0;
         pose_expect_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               ddo_pkg::CSR_MAX_SPEED:  speed_limit = {33'd0, csr_wdata[30:0]};
               ddo_pkg::CSR_WHEEL_DIST: track_width = {33'd0, csr_wdata[30:0]};
               ddo_pkg::CSR_OFFSET_X:   ref_off_x = longint'($signed(csr_wdata));
               ddo_pkg::CSR_OFFSET_Y:   ref_off_y = longint'($signed(csr_wdata));
               ddo_pkg::CSR_TIME_STEP:  step_len = {32'd0, csr_wdata};
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pose_expect_q.push_back(predict_pose(req_tuser,
               longint'($signed(req_tdata[31:0])), longint'($signed(req_tdata[63:32]))));
         if (rsp_tvalid && rsp_tready) begin
            g = rsp_tdata[190:0];
            if (pose_expect_q.size() == 0) begin
               $display("%0t: unexpected result transfer, got %h", $time, g);
               errors <= errors + 1;
            end else begin
               e = pose_expect_q.pop_front();
               bad = field_differs("position_x", e.x, g.x)
                   + field_differs("position_y", e.y, g.y)
                   + field_differs("heading_angle", {1'b0, e.hd}, {1'b0, g.hd})
                   + field_differs("elapsed_ticks", e.ticks, g.ticks)
                   + field_differs("left_wheel_speed", e.left, g.left)
                   + field_differs("right_wheel_speed", e.right, g.right);
               if (bad != 0) errors <= errors + 1;
            end
         end
      end
      pending <= pose_expect_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// ----- dv/differential_drive_odometry_core_tb.sv -----
module differential_drive_odometry_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_wr_en = 0;
   logic [2:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // first_command, second_command
   logic [1:0]   req_tuser = '0;   // operation
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // position_x, position_y, heading_angle, elapsed_ticks, left_wheel_speed,
   // right_wheel_speed, zero pad
   logic [191:0] rsp_tdata;

   int errors, pending;
   int sent = 0;
   int burst_left = 0;
   int hold_cnt = 0;
   bit held = 0;
   int idle_cycles = 0;
   int ready_mode = 0;
   int mode_left = 0;

   differential_drive_odometry_core dut (.*);

   differential_drive_odometry_core_checker chk (.*);

   initial forever #5 clock = ~clock;

   // receiver stall pattern, with one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (!held && sent >= 300) begin
         held = 1;
         hold_cnt = 400;
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 0;
      end else case (ready_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("differential_drive_odometry_core_tb failed");
         $finish;
      end
   end

   task automatic send(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] ms, input logic [31:0] wd, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [31:0] dt);
      logic [31:0] vals [5];
      logic [2:0]  idx [5];
      vals = '{ms, wd, ox, oy, dt};
      idx = '{ddo_pkg::CSR_MAX_SPEED, ddo_pkg::CSR_WHEEL_DIST, ddo_pkg::CSR_OFFSET_X,
              ddo_pkg::CSR_OFFSET_Y, ddo_pkg::CSR_TIME_STEP};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1;
         csr_addr <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 0;
   endtask

   function automatic logic [31:0] pick_edge();
      case ($urandom_range(0, 4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'h1;
         default: return 32'hffffffff;
      endcase
   endfunction

   function automatic logic [31:0] rand_cmd();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return pick_edge();
         default: return 32'($urandom_range(0, 26214400)) - 32'd13107200;
      endcase
   endfunction

   function automatic logic [1:0] rand_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return ddo_pkg::OP_SET_WHEELS;
      if (r < 30) return ddo_pkg::OP_SET_DRIVE;
      if (r < 95) return ddo_pkg::OP_ADVANCE;
      return OP_UNUSED;
   endfunction

   task automatic random_regs();
      logic [31:0] ms, wd, ox, oy, dt;
      ms = ($urandom_range(0, 3) == 0) ? pick_edge() & 32'h7fffffff : $urandom_range(0, 13107200);
      wd = ($urandom_range(0, 3) == 0) ? pick_edge() & 32'h7fffffff
                                      : $urandom_range(16384, 3276800);
      ox = ($urandom_range(0, 3) == 0) ? pick_edge() : 32'($urandom_range(0, 655360)) - 32'd327680;
      oy = ($urandom_range(0, 3) == 0) ? pick_edge() : 32'($urandom_range(0, 655360)) - 32'd327680;
      dt = ($urandom_range(0, 4) == 0) ? pick_edge() : $urandom_range(0, 65536);
      set_regs(ms, wd, ox, oy, dt);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset defaults: saturating wheels, drive mixing, steps, unused op
      send(ddo_pkg::OP_SET_WHEELS, 32'h7fffffff, 32'h80000000);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      send(ddo_pkg::OP_SET_WHEELS, 32'h80000000, 32'h7fffffff);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      send(ddo_pkg::OP_SET_DRIVE, 32'h00050000, 32'h00010000);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      send(OP_UNUSED, 32'hffffffff, 32'hffffffff);
      send(ddo_pkg::OP_SET_DRIVE, 32'h7fffffff, 32'h80000000);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      drain();

      // widest limits, zero track width, huge step: overflow and heading wrap
      set_regs(32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      send(ddo_pkg::OP_SET_WHEELS, 32'h80000000, 32'h7fffffff);
      repeat (3) send(ddo_pkg::OP_ADVANCE, $urandom, $urandom);
      send(ddo_pkg::OP_SET_DRIVE, 32'h80000000, 32'h7fffffff);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      send(OP_UNUSED, 0, 0);
      drain();

      set_regs(32'h0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0);
      send(ddo_pkg::OP_SET_WHEELS, 32'h7fffffff, 32'h80000000);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      send(ddo_pkg::OP_SET_DRIVE, 32'h7fffffff, 32'h7fffffff);
      send(ddo_pkg::OP_ADVANCE, 0, 0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         random_regs();
         for (int n = 0; n < 105; n++)
            send(rand_op(), rand_cmd(), rand_cmd());
         drain();
      end

      if (errors == 0) begin
         $display("differential_drive_odometry_core_tb passed");
      end else begin
         $display("differential_drive_odometry_core_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_front.sv
rtl/ddo_cordic.sv
rtl/ddo_divider.sv
rtl/ddo_exec.sv
rtl/differential_drive_odometry_core.sv
dv/differential_drive_odometry_core_checker.sv
dv/differential_drive_odometry_core_tb.sv
